FILE: hdl/asf_pkg.sv
`default_nettype none

package asf_pkg;

    // Operation codes carried by the input word
    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_FILTER = 2'd3
    } t_op;

    // Status codes returned with each result word
    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_OVERFLOW = 2'd1,
        STS_EMPTY    = 2'd2
    } t_status;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_FILT,
        S_RESP
    } t_state;

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int VALUE_W  = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 8;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_FILTER_KEY = 1'b0;   // word address of filter_key

endpackage

`default_nettype wire

FILE: hdl/array_stack_with_filter.sv
`default_nettype none

// LIFO stack of symbol codes with an in-place filter.
//
// Input channel: i_in_valid / o_in_stall carry one word of i_opcode and
// i_push_value (push, pop, peek, filter). Output channel: o_out_valid /
// i_out_stall carry one result word per input word (read value, status,
// entry count, empty and full flags). Words are taken on an edge where
// valid is high and stall is low.
// Path to the result register: push, or any operation that fails or finds
// the stack empty, loads it on accept; pop and peek first do one synchronous
// read of the stack memory, and filter streams every entry through the single
// read port and writes survivors back through the write port; both then load
// it from the response state. One word is worked on at a time.
// The output register decouples the two sides: a new word is taken while
// the previous result waits, as long as the register is emptied that cycle.
// A stalled receiver holds the result and, once the register is full,
// stalls the input side.
// Reset clears the fill level (empty stack), the filter key and the
// output valid; stack memory contents are not cleared.
// filter_key lives at APB byte address 0.
module array_stack_with_filter
    import asf_pkg::*;
#(
    parameter int DEPTH        = 128,
    parameter int SYMBOL_WIDTH = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,

    // input words
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [OP_W-1:0]       i_opcode,
    input  wire logic [VALUE_W-1:0]    i_push_value,

    // result words
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic      [VALUE_W-1:0]    o_read_value,
    output logic      [STATUS_W-1:0]   o_status,
    output logic      [COUNT_W-1:0]    o_entry_count,
    output logic                       o_is_empty,
    output logic                       o_is_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // memory address
    localparam int CW = $clog2(DEPTH + 1);                  // fill level 0..DEPTH
    localparam int SW = SYMBOL_WIDTH;
    localparam logic [CW-1:0] FULL_LEVEL = CW'(DEPTH);
    localparam logic [CW-1:0] ONE        = CW'(1);

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [VALUE_W-1:0] r_filter_key;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_FILTER_KEY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_key <= '0;
        end else if (cfg_wr) begin
            r_filter_key <= pwdata[VALUE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_FILTER_KEY) begin
            prdata = {{(APB_DATA_W-VALUE_W){1'b0}}, r_filter_key};
        end
    end

    // Field values brought to symbol width (masked or zero-extended)
    logic [SW+VALUE_W-1:0] push_ext;
    logic [SW+VALUE_W-1:0] key_ext;
    logic [SW-1:0]         push_sym;
    logic [SW-1:0]         key_sym;

    assign push_ext = {{SW{1'b0}}, i_push_value};
    assign key_ext  = {{SW{1'b0}}, r_filter_key};
    assign push_sym = push_ext[SW-1:0];
    assign key_sym  = key_ext[SW-1:0];

    // ---------------------------------------------------------------
    // Stack memory: one write port, one registered read port.
    // Reads and writes never hit the same entry in one cycle: a push is
    // complete before the next word's read, and during a filter the write
    // index always trails the read index.
    // ---------------------------------------------------------------
    logic [SW-1:0] r_stack [DEPTH];
    logic [SW-1:0] r_rd_data;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [SW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_stack[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= r_stack[mem_raddr];
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    t_state        r_state, n_state;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_rd_idx, n_rd_idx;      // next entry to read (filter)
    logic [CW-1:0] r_wr_idx, n_wr_idx;      // next slot to keep (filter)
    logic          r_pend_rd, n_pend_rd;    // pending result carries read data
    t_status       r_pend_sts, n_pend_sts;

    logic          r_out_valid;
    logic          out_free;
    logic          in_accept;
    logic          out_load;
    logic [SW-1:0] ld_value;
    t_status       ld_sts;
    logic          keep;
    logic [CW-1:0] wr_next;
    logic [CW-1:0] fill_dec;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign in_accept = i_in_valid && !o_in_stall;
    assign keep      = (r_rd_data != key_sym);
    assign wr_next   = r_wr_idx + (keep ? ONE : '0);
    assign fill_dec  = r_fill - ONE;

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_rd_idx   = r_rd_idx;
        n_wr_idx   = r_wr_idx;
        n_pend_rd  = r_pend_rd;
        n_pend_sts = r_pend_sts;
        o_in_stall = 1'b1;
        out_load   = 1'b0;
        ld_value   = '0;
        ld_sts     = STS_OK;
        mem_we     = 1'b0;
        mem_waddr  = r_fill[AW-1:0];
        mem_wdata  = push_sym;
        mem_re     = 1'b0;
        mem_raddr  = fill_dec[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                o_in_stall = !out_free;
                if (in_accept) begin
                    unique case (t_op'(i_opcode))
                        OP_PUSH: begin
                            out_load = 1'b1;
                            if (r_fill == FULL_LEVEL) begin
                                ld_sts = STS_OVERFLOW;
                            end else begin
                                mem_we = 1'b1;
                                n_fill = r_fill + ONE;
                            end
                        end
                        OP_POP, OP_PEEK: begin
                            if (r_fill == '0) begin
                                out_load = 1'b1;
                                ld_sts   = STS_EMPTY;
                            end else begin
                                mem_re     = 1'b1;
                                n_pend_rd  = 1'b1;
                                n_pend_sts = STS_OK;
                                n_state    = S_RESP;
                                if (t_op'(i_opcode) == OP_POP) begin
                                    n_fill = fill_dec;
                                end
                            end
                        end
                        OP_FILTER: begin
                            if (r_fill == '0) begin
                                out_load = 1'b1;
                            end else begin
                                mem_re     = 1'b1;
                                mem_raddr  = '0;
                                n_rd_idx   = ONE;
                                n_wr_idx   = '0;
                                n_pend_rd  = 1'b0;
                                n_pend_sts = STS_OK;
                                n_state    = S_FILT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FILT: begin
                // r_rd_data holds entry r_rd_idx-1; survivors compact downwards
                mem_we    = keep;
                mem_waddr = r_wr_idx[AW-1:0];
                mem_wdata = r_rd_data;
                if (r_rd_idx < r_fill) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_rd_idx[AW-1:0];
                    n_rd_idx  = r_rd_idx + ONE;
                    n_wr_idx  = wr_next;
                end else begin
                    n_fill  = wr_next;
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    out_load = 1'b1;
                    ld_value = r_pend_rd ? r_rd_data : '0;
                    ld_sts   = r_pend_sts;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_wr_idx   <= n_wr_idx;
        r_pend_rd  <= n_pend_rd;
        r_pend_sts <= n_pend_sts;
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic [VALUE_W-1:0]    r_read_value;
    logic [STATUS_W-1:0]   r_status;
    logic [COUNT_W-1:0]    r_entry_count;
    logic                  r_is_empty;
    logic                  r_is_full;
    logic [SW+VALUE_W-1:0] ld_value_ext;
    logic [CW+COUNT_W-1:0] ld_count_ext;

    assign ld_value_ext = {{VALUE_W{1'b0}}, ld_value};
    assign ld_count_ext = {{COUNT_W{1'b0}}, n_fill};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_read_value  <= ld_value_ext[VALUE_W-1:0];
            r_status      <= ld_sts;
            r_entry_count <= ld_count_ext[COUNT_W-1:0];
            r_is_empty    <= (n_fill == '0);
            r_is_full     <= (n_fill == FULL_LEVEL);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_read_value;
    assign o_status      = r_status;
    assign o_entry_count = r_entry_count;
    assign o_is_empty    = r_is_empty;
    assign o_is_full     = r_is_full;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_LEVEL)
        else $error("fill level beyond depth");

    a_filter_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILT) |-> (r_wr_idx < r_rd_idx) && (r_rd_idx <= r_fill))
        else $error("filter write index overtook read index");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == STS_OVERFLOW)) |-> r_is_full)
        else $error("overflow reported on a stack that is not full");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (t_op'(i_opcode) == OP_PUSH) && (r_fill != FULL_LEVEL))
        |=> (r_fill == $past(r_fill) + ONE))
        else $error("push did not raise the fill level");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
